>>> rtl/core/prdq_pkg.sv
// prdq_pkg: shared constants, status codes, controller states and the
// command/status bundles between the controller and the datapath.
// no dependencies.
package prdq_pkg;

    localparam int MAX_PENDING_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int ID_W            = 16;
    localparam int KEY_W           = 2 * ID_W;
    localparam int REQ_W           = 4 * ID_W;
    localparam int CNT_W           = 32;
    localparam int OCC_W           = 4;
    localparam int STATUS_W        = 3;
    localparam int CMP_W           = 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED  = 3'd0,
        ST_INVALID   = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_QFAIL     = 3'd4,
        ST_CONSUMED  = 3'd5,
        ST_EMPTY     = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_ADMIT,
        S_POP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    load;
        logic    rd_head;
        logic    rd_scan;
        logic    inc_req;
        logic    inc_sup;
        logic    push;
        logic    pop;
        logic    st_we;
        status_t st_code;
        logic    out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic mode;
        logic invalid;
        logic fill_zero;
        logic scan_last;
        logic match;
        logic pend_full;
        logic queue_full;
    } dp_stat_t;

endpackage

>>> rtl/core/prdq_ctrl.sv
// prdq_ctrl: sequencing state machine for one word at a time
// and the result valid flag. depends on prdq_pkg.
module prdq_ctrl
    import prdq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.mode)
                begin
                    state_next = stat.fill_zero ? S_DONE : S_POP;
                end
                else if (stat.invalid)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = stat.fill_zero ? S_ADMIT : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.match)
                begin
                    state_next = S_DONE;
                end
                else if (stat.scan_last)
                begin
                    state_next = S_ADMIT;
                end
            end
            S_ADMIT: state_next = S_DONE;
            S_POP:   state_next = S_DONE;
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.st_code = ST_ACCEPTED;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_DECIDE:
            begin
                if (stat.mode)
                begin
                    if (stat.fill_zero)
                    begin
                        cmd.st_we   = 1'b1;
                        cmd.st_code = ST_EMPTY;
                    end
                    else
                    begin
                        cmd.rd_head = 1'b1;
                    end
                end
                else if (stat.invalid)
                begin
                    cmd.st_we   = 1'b1;
                    cmd.st_code = ST_INVALID;
                end
                else
                begin
                    cmd.inc_req = 1'b1;
                    cmd.rd_head = !stat.fill_zero;
                end
            end
            S_SCAN:
            begin
                if (stat.match)
                begin
                    cmd.inc_sup = 1'b1;
                    cmd.st_we   = 1'b1;
                    cmd.st_code = ST_DUPLICATE;
                end
                else if (!stat.scan_last)
                begin
                    cmd.rd_scan = 1'b1;
                end
            end
            S_ADMIT:
            begin
                cmd.st_we = 1'b1;
                if (stat.pend_full)
                begin
                    cmd.st_code = ST_FULL;
                end
                else if (stat.queue_full)
                begin
                    cmd.st_code = ST_QFAIL;
                end
                else
                begin
                    cmd.push    = 1'b1;
                    cmd.st_code = ST_ACCEPTED;
                end
            end
            S_POP:
            begin
                cmd.pop     = 1'b1;
                cmd.st_we   = 1'b1;
                cmd.st_code = ST_CONSUMED;
            end
            S_DONE:
            begin
                cmd.out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/core/prdq_datapath.sv
// prdq_datapath: request capture, queue store with one read and one write
// port, serial destination match, counters and result register. depends on prdq_pkg.
module prdq_datapath
    import prdq_pkg::*;
#(
    parameter int MAX_PENDING = MAX_PENDING_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic              cfg_data,
    input  logic              mode,
    input  logic [ID_W-1:0]   dest_network,
    input  logic [ID_W-1:0]   dest_node,
    input  logic [ID_W-1:0]   hop_network,
    input  logic [ID_W-1:0]   hop_node,
    input  ctrl_cmd_t         cmd,
    output dp_stat_t          stat,
    output logic [STATUS_W-1:0] status,
    output logic [ID_W-1:0]   out_dest_network,
    output logic [ID_W-1:0]   out_dest_node,
    output logic [ID_W-1:0]   out_hop_network,
    output logic [ID_W-1:0]   out_hop_node,
    output logic [OCC_W-1:0]  occupancy,
    output logic [CNT_W-1:0]  total_requests,
    output logic [CNT_W-1:0]  total_suppressed,
    output logic [CNT_W-1:0]  total_consumed
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    logic                enabled_reg;
    logic                enabled_next;
    logic                mode_reg;
    logic                mode_next;
    logic [REQ_W-1:0]    req_reg;
    logic [REQ_W-1:0]    req_next;
    logic [REQ_W-1:0]    shown_reg;
    logic [REQ_W-1:0]    shown_next;
    logic [REQ_W-1:0]    mem [QUEUE_DEPTH];
    logic [REQ_W-1:0]    rd_data_reg;
    logic [PTR_W-1:0]    rd_addr;
    logic [PTR_W-1:0]    head_reg;
    logic [PTR_W-1:0]    head_next;
    logic [PTR_W-1:0]    tail_reg;
    logic [PTR_W-1:0]    tail_next;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;
    logic [PTR_W-1:0]    scan_ptr_reg;
    logic [PTR_W-1:0]    scan_ptr_next;
    logic [FILL_W-1:0]   scan_cnt_reg;
    logic [FILL_W-1:0]   scan_cnt_next;
    logic [CNT_W-1:0]    req_cnt_reg;
    logic [CNT_W-1:0]    req_cnt_next;
    logic [CNT_W-1:0]    sup_cnt_reg;
    logic [CNT_W-1:0]    sup_cnt_next;
    logic [CNT_W-1:0]    con_cnt_reg;
    logic [CNT_W-1:0]    con_cnt_next;
    status_t             st_reg;
    status_t             st_next;
    status_t             out_st_reg;
    status_t             out_st_next;
    logic [REQ_W-1:0]    out_req_reg;
    logic [REQ_W-1:0]    out_req_next;
    logic [OCC_W-1:0]    out_occ_reg;
    logic [OCC_W-1:0]    out_occ_next;
    logic [CNT_W-1:0]    out_req_cnt_reg;
    logic [CNT_W-1:0]    out_req_cnt_next;
    logic [CNT_W-1:0]    out_sup_cnt_reg;
    logic [CNT_W-1:0]    out_sup_cnt_next;
    logic [CNT_W-1:0]    out_con_cnt_reg;
    logic [CNT_W-1:0]    out_con_cnt_next;

    // request layout: dest network, dest node, hop network, hop node
    assign stat.mode       = mode_reg;
    assign stat.invalid    = !enabled_reg
                           || (req_reg[4*ID_W-1:3*ID_W] == '0)
                           || (req_reg[3*ID_W-1:2*ID_W] == '0)
                           || (req_reg[2*ID_W-1:ID_W] == '0)
                           || (req_reg[ID_W-1:0] == '0);
    assign stat.fill_zero  = (fill_reg == '0);
    assign stat.scan_last  = (scan_cnt_reg == fill_reg);
    assign stat.match      = (rd_data_reg[REQ_W-1:REQ_W-KEY_W] == req_reg[REQ_W-1:REQ_W-KEY_W]);
    assign stat.pend_full  = (CMP_W'(fill_reg) >= CMP_W'(MAX_PENDING));
    assign stat.queue_full = (CMP_W'(fill_reg) >= CMP_W'(QUEUE_DEPTH));

    assign rd_addr = cmd.rd_head ? head_reg : scan_ptr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[tail_reg] <= req_reg;
        end
        if (cmd.rd_head || cmd.rd_scan)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        enabled_next     = cfg_valid ? cfg_data : enabled_reg;
        mode_next        = cmd.load ? mode : mode_reg;
        req_next         = cmd.load ? {dest_network, dest_node, hop_network, hop_node}
                                    : req_reg;
        shown_next       = shown_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        fill_next        = fill_reg;
        scan_ptr_next    = scan_ptr_reg;
        scan_cnt_next    = scan_cnt_reg;
        req_cnt_next     = cmd.inc_req ? req_cnt_reg + 1'b1 : req_cnt_reg;
        sup_cnt_next     = cmd.inc_sup ? sup_cnt_reg + 1'b1 : sup_cnt_reg;
        con_cnt_next     = cmd.pop ? con_cnt_reg + 1'b1 : con_cnt_reg;
        st_next          = cmd.st_we ? cmd.st_code : st_reg;
        if (cmd.load)
        begin
            shown_next = '0;
        end
        if (cmd.rd_head)
        begin
            scan_ptr_next = ptr_inc(head_reg);
            scan_cnt_next = FILL_W'(1);
        end
        else if (cmd.rd_scan)
        begin
            scan_ptr_next = ptr_inc(scan_ptr_reg);
            scan_cnt_next = scan_cnt_reg + 1'b1;
        end
        if (cmd.push)
        begin
            tail_next = ptr_inc(tail_reg);
            fill_next = fill_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            head_next  = ptr_inc(head_reg);
            fill_next  = fill_reg - 1'b1;
            shown_next = rd_data_reg;
        end
    end

    always_comb
    begin
        out_st_next      = out_st_reg;
        out_req_next     = out_req_reg;
        out_occ_next     = out_occ_reg;
        out_req_cnt_next = out_req_cnt_reg;
        out_sup_cnt_next = out_sup_cnt_reg;
        out_con_cnt_next = out_con_cnt_reg;
        if (cmd.out_load)
        begin
            out_st_next      = st_reg;
            out_req_next     = shown_reg;
            out_occ_next     = OCC_W'(fill_reg);
            out_req_cnt_next = req_cnt_reg;
            out_sup_cnt_next = sup_cnt_reg;
            out_con_cnt_next = con_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg  <= 1'b1;
            head_reg     <= '0;
            tail_reg     <= '0;
            fill_reg     <= '0;
            scan_ptr_reg <= '0;
            scan_cnt_reg <= '0;
            req_cnt_reg  <= '0;
            sup_cnt_reg  <= '0;
            con_cnt_reg  <= '0;
        end
        else
        begin
            enabled_reg  <= enabled_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            fill_reg     <= fill_next;
            scan_ptr_reg <= scan_ptr_next;
            scan_cnt_reg <= scan_cnt_next;
            req_cnt_reg  <= req_cnt_next;
            sup_cnt_reg  <= sup_cnt_next;
            con_cnt_reg  <= con_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        req_reg         <= req_next;
        shown_reg       <= shown_next;
        st_reg          <= st_next;
        out_st_reg      <= out_st_next;
        out_req_reg     <= out_req_next;
        out_occ_reg     <= out_occ_next;
        out_req_cnt_reg <= out_req_cnt_next;
        out_sup_cnt_reg <= out_sup_cnt_next;
        out_con_cnt_reg <= out_con_cnt_next;
    end

    assign status           = out_st_reg;
    assign out_dest_network = out_req_reg[4*ID_W-1:3*ID_W];
    assign out_dest_node    = out_req_reg[3*ID_W-1:2*ID_W];
    assign out_hop_network  = out_req_reg[2*ID_W-1:ID_W];
    assign out_hop_node     = out_req_reg[ID_W-1:0];
    assign occupancy        = out_occ_reg;
    assign total_requests   = out_req_cnt_reg;
    assign total_suppressed = out_sup_cnt_reg;
    assign total_consumed   = out_con_cnt_reg;

endmodule

>>> rtl/core/pending_request_dedup_queue.sv
// pending_request_dedup_queue: top level joining prdq_ctrl and prdq_datapath.
// depends on prdq_pkg, prdq_ctrl, prdq_datapath.
//
// Admits route repair requests into a queue of QUEUE_DEPTH entries while
// suppressing requests whose destination is already queued, and hands the
// queued requests out in order on consume words. One word is in work at a
// time. For a new request the destination is compared against one queued
// entry per cycle through the single read port of the queue store, and a
// duplicate stops the scan at the first hit. A consume reads the head entry
// and pops it; an invalid request or a consume on an empty queue goes
// straight to the result. The finished result sits in an output register,
// so the next word can be taken in the cycle after the result is loaded,
// while the result still waits. The enable register resets to 1;
// cfg_ready is always high.
module pending_request_dedup_queue
    import prdq_pkg::*;
#(
    parameter int MAX_PENDING = MAX_PENDING_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                mode,
    input  logic [ID_W-1:0]     dest_network,
    input  logic [ID_W-1:0]     dest_node,
    input  logic [ID_W-1:0]     hop_network,
    input  logic [ID_W-1:0]     hop_node,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [ID_W-1:0]     out_dest_network,
    output logic [ID_W-1:0]     out_dest_node,
    output logic [ID_W-1:0]     out_hop_network,
    output logic [ID_W-1:0]     out_hop_node,
    output logic [OCC_W-1:0]    occupancy,
    output logic [CNT_W-1:0]    total_requests,
    output logic [CNT_W-1:0]    total_suppressed,
    output logic [CNT_W-1:0]    total_consumed
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    prdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    prdq_datapath #(
        .MAX_PENDING (MAX_PENDING),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_data         (cfg_data),
        .mode             (mode),
        .dest_network     (dest_network),
        .dest_node        (dest_node),
        .hop_network      (hop_network),
        .hop_node         (hop_node),
        .cmd              (cmd),
        .stat             (stat),
        .status           (status),
        .out_dest_network (out_dest_network),
        .out_dest_node    (out_dest_node),
        .out_hop_network  (out_hop_network),
        .out_hop_node     (out_hop_node),
        .occupancy        (occupancy),
        .total_requests   (total_requests),
        .total_suppressed (total_suppressed),
        .total_consumed   (total_consumed)
    );

endmodule

>>> rtl/core/prdq_checker.sv
// prdq_checker: port level assertions for pending_request_dedup_queue,
// attached by bind. depends on prdq_pkg.
module prdq_checker
    import prdq_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STATUS_W-1:0] status,
    input logic [ID_W-1:0]     out_dest_network,
    input logic [ID_W-1:0]     out_dest_node,
    input logic [ID_W-1:0]     out_hop_network,
    input logic [ID_W-1:0]     out_hop_node,
    input logic [OCC_W-1:0]    occupancy
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(occupancy))
        else $error("result changed while stalled");

    // one word in work at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word taken while busy");

    // request ids shown only on a consume
    a_shown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_CONSUMED) |->
            (out_dest_network == '0) && (out_dest_node == '0)
            && (out_hop_network == '0) && (out_hop_node == '0))
        else $error("ids shown on a non consume result");

    // empty queue means nothing pending
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> (occupancy == '0))
        else $error("empty result with pending entries");

endmodule

bind pending_request_dedup_queue prdq_checker u_prdq_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .out_dest_network (out_dest_network),
    .out_dest_node    (out_dest_node),
    .out_hop_network  (out_hop_network),
    .out_hop_node     (out_hop_node),
    .occupancy        (occupancy)
);
